// ===== hdl/sptq_pkg.sv =====
`timescale 1ns / 1ps

package sptq_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 16;
	localparam int TAG_W = 8;
	localparam int PRIO_W = 8;
	localparam int OCC_W = 5;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_PUSHED = 2'd0,
		ST_POPPED = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// one queued task: tag and signed priority
	typedef struct packed {
		logic [TAG_W-1:0]         tag;
		logic signed [PRIO_W-1:0] prio;
	} entry_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

endpackage

// ===== hdl/sptq_if.sv =====
`timescale 1ns / 1ps

// request channel: one push or pop word
interface sptq_req_if import sptq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	opcode_t                  opcode;
	logic [TAG_W-1:0]         task_tag;
	logic signed [PRIO_W-1:0] task_priority;

	modport source (output valid, opcode, task_tag, task_priority, input ready);
	modport sink (input valid, opcode, task_tag, task_priority, output ready);
endinterface

// response channel: one result word per request
interface sptq_rsp_if import sptq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	status_t                  status;
	logic [TAG_W-1:0]         popped_tag;
	logic signed [PRIO_W-1:0] popped_priority;
	logic [OCC_W-1:0]         occupancy;

	modport source (output valid, status, popped_tag, popped_priority, occupancy,
		input ready);
	modport sink (input valid, status, popped_tag, popped_priority, occupancy,
		output ready);
endinterface

// ===== hdl/sptq_cell.sv =====
`timescale 1ns / 1ps

module sptq_cell import sptq_pkg::*; (
	input  logic       clk,
	input  logic       occupied,
	input  cell_ctrl_t ctrl,
	input  entry_t     new_word,
	input  entry_t     left_word,
	input  logic       left_ins,
	input  entry_t     right_word,
	output entry_t     word,
	output logic       ins
);

	entry_t word_q;

	// new task goes at or before this cell when this one is free or strictly lower
	assign ins = !occupied || ($signed(word_q.prio) < $signed(new_word.prio));
	assign word = word_q;

	// push shifts toward the tail from the insert point, pop shifts toward the head
	always_ff @(posedge clk) begin
		priority if (ctrl.push) begin
			priority if (left_ins) begin
				word_q <= left_word;
			end else if (ins) begin
				word_q <= new_word;
			end else begin
				word_q <= word_q;
			end
		end else if (ctrl.pop) begin
			word_q <= right_word;
		end else begin
			word_q <= word_q;
		end
	end

endmodule

// ===== hdl/stable_priority_task_queue_core.sv =====
`timescale 1ns / 1ps

// Priority queue of task tags, highest priority at the head, equal priorities
// leave in arrival order.
// req channel: opcode push (tag, priority) or pop. rsp channel: one word per
// request with status, popped tag and priority (zero unless popped) and the
// occupancy after the request.
// Each request is accepted on a valid/ready edge, the row of cells updates at
// that edge and the response is registered, so rsp.valid rises the next cycle.
// One request per cycle is sustained while rsp.ready stays high; the cell row
// compares every entry in parallel, one priority compare per cell sets the
// cycle.
// A push into a full queue is dropped with status full, a pop from an empty
// queue returns status empty.
// Reset (arst_n low) empties the queue and drops any pending response; cell
// contents are not cleared, the occupancy count marks what is live.
// When the receiver stalls, the response holds and req.ready drops until the
// response is taken.
module stable_priority_task_queue_core import sptq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input logic       clk,
	input logic       arst_n,
	sptq_req_if.sink  req,
	sptq_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]       count_q;
	entry_t                 cell_word [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_ins;
	entry_t                 new_word;
	cell_ctrl_t             ctrl;
	logic                   accept;
	logic                   is_push;
	logic                   full;
	logic                   empty;

	logic                     rsp_valid_q;
	status_t                  status_q;
	logic [TAG_W-1:0]         tag_q;
	logic signed [PRIO_W-1:0] prio_q;
	logic [OCC_W-1:0]         occ_q;
	logic [CNT_W-1:0]         count_next;

	// handshake and command decode
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_push   = (req.opcode == OP_PUSH);
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign ctrl.push = accept && is_push && !full;
	assign ctrl.pop  = accept && !is_push && !empty;
	assign new_word.tag  = req.task_tag;
	assign new_word.prio = req.task_priority;

	// row of cells, head at index zero
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_word;
		logic   left_ins;
		entry_t right_word;
		logic   occupied;

		assign occupied = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_word = new_word;
			assign left_ins  = 1'b0;
		end else begin : g_body
			assign left_word = cell_word[i-1];
			assign left_ins  = cell_ins[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_word = cell_word[i];
		end else begin : g_inner
			assign right_word = cell_word[i+1];
		end

		sptq_cell u_cell (
			.clk        (clk),
			.occupied   (occupied),
			.ctrl       (ctrl),
			.new_word   (new_word),
			.left_word  (left_word),
			.left_ins   (left_ins),
			.right_word (right_word),
			.word       (cell_word[i]),
			.ins        (cell_ins[i])
		);
	end

	// occupancy after this request
	always_comb begin
		count_next = count_q;
		priority if (ctrl.push) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctrl.pop) begin
			count_next = count_q - CNT_W'(1);
		end else begin
			count_next = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			occ_q <= OCC_W'(count_next);
			if (ctrl.pop) begin
				tag_q  <= cell_word[0].tag;
				prio_q <= cell_word[0].prio;
			end else begin
				tag_q  <= '0;
				prio_q <= '0;
			end
			unique case ({is_push, full, empty})
				3'b110:  status_q <= ST_FULL;
				3'b100, 3'b101: status_q <= ST_PUSHED;
				3'b001:  status_q <= ST_EMPTY;
				default: status_q <= ST_POPPED;
			endcase
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = status_q;
	assign rsp.popped_tag      = tag_q;
	assign rsp.popped_priority = prio_q;
	assign rsp.occupancy       = occ_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("occupancy count beyond queue depth");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("push did not advance the count");

	a_pop_status: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |=> rsp.valid && rsp.status == ST_POPPED)
		else $error("pop did not report popped status");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("request taken while response stalled");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(2) |->
			$signed(cell_word[0].prio) >= $signed(cell_word[1].prio))
		else $error("head entries out of priority order");
`endif

endmodule

// ===== tb/stable_priority_task_queue_core_tb.sv =====
`timescale 1ns / 1ps

module stable_priority_task_queue_core_tb;
	import sptq_pkg::*;

	localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
	localparam int RANDOM_WORDS = 900;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD_CYCLES = 80;

	// one expected response word
	typedef struct {
		status_t                  status;
		logic [TAG_W-1:0]         tag;
		logic signed [PRIO_W-1:0] prio;
		logic [OCC_W-1:0]         occ;
	} response_t;

	// shadow of the sorted task queue and the responses it owes
	class task_queue_tracker;
		logic [TAG_W-1:0]         tags [DEPTH];
		logic signed [PRIO_W-1:0] prios [DEPTH];
		int unsigned              count;
		response_t                pending_results [$];
		int                       errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		// work out the response of an accepted request and advance the queue
		function void note_request(opcode_t op, logic [TAG_W-1:0] tag,
				logic signed [PRIO_W-1:0] prio);
			response_t r;
			int unsigned pos;
			r.tag = '0;
			r.prio = '0;
			if (op == OP_PUSH) begin
				if (count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// insert ahead of the first strictly lower priority
					pos = count;
					for (int unsigned i = 0; i < count; i++) begin
						if (prios[i] < prio) begin
							pos = i;
							break;
						end
					end
					for (int unsigned i = count; i > pos; i--) begin
						tags[i] = tags[i-1];
						prios[i] = prios[i-1];
					end
					tags[pos] = tag;
					prios[pos] = prio;
					count++;
					r.status = ST_PUSHED;
				end
			end else begin
				if (count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.tag = tags[0];
					r.prio = prios[0];
					for (int unsigned i = 1; i < count; i++) begin
						tags[i-1] = tags[i];
						prios[i-1] = prios[i];
					end
					count--;
					r.status = ST_POPPED;
				end
			end
			r.occ = OCC_W'(count);
			pending_results = {pending_results, r};
		endfunction

		// compare a taken response with the oldest expectation
		function void check_response(status_t status, logic [TAG_W-1:0] tag,
				logic signed [PRIO_W-1:0] prio, logic [OCC_W-1:0] occ);
			response_t r;
			if (pending_results.size() == 0) begin
				$error("response word with no request outstanding");
				errors++;
				return;
			end
			r = pending_results[0];
			pending_results.delete(0);
			if (status !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, status);
				errors++;
			end
			if (tag !== r.tag) begin
				$error("popped_tag: expected %0d, got %0d", r.tag, tag);
				errors++;
			end
			if (prio !== r.prio) begin
				$error("popped_priority: expected %0d, got %0d", r.prio, prio);
				errors++;
			end
			if (occ !== r.occ) begin
				$error("occupancy: expected %0d, got %0d", r.occ, occ);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int unsigned cycle_count;
	int unsigned words_sent;
	int unsigned burst_left;
	bit long_hold_request;

	task_queue_tracker tracker;

	sptq_req_if req ();
	sptq_rsp_if rsp ();

	stable_priority_task_queue_core #(.QUEUE_DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL stable_priority_task_queue_core");
			$finish;
		end
	end

	// response checking
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			tracker.check_response(rsp.status, rsp.popped_tag, rsp.popped_priority,
				rsp.occupancy);
	end

	// receiver: stall patterns that change every so often, plus one long hold-off
	initial begin
		int unsigned mode;
		int unsigned mode_left;
		int unsigned phase;
		mode = 0;
		mode_left = 0;
		phase = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_request) begin
				long_hold_request = 1'b0;
				rsp.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 100);
				end
				mode_left--;
				phase++;
				case (mode)
					0: rsp.ready <= 1'b1;
					1: rsp.ready <= ($urandom_range(0, 3) != 0);
					2: rsp.ready <= ($urandom_range(0, 9) < 3);
					default: rsp.ready <= (phase % 5 != 0) && (phase % 7 != 3);
				endcase
			end
		end
	end

	// offer one request word, optionally with bursty gaps ahead of it; starts and
	// ends on a falling edge
	task automatic offer_word(opcode_t op, logic [TAG_W-1:0] tag,
			logic signed [PRIO_W-1:0] prio, bit idle_on);
		int unsigned gap;
		if (idle_on) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				burst_left = $urandom_range(1, 16);
				req.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left--;
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.task_tag <= tag;
		req.task_priority <= prio;
		do @(posedge clk); while (!req.ready);
		tracker.note_request(op, tag, prio);
		words_sent++;
		@(negedge clk);
	endtask

	// sender pause until every response is back
	task automatic wait_for_drain();
		req.valid <= 1'b0;
		while (tracker.pending_results.size() != 0) @(negedge clk);
	endtask

	function automatic logic signed [PRIO_W-1:0] pick_priority(int unsigned mode);
		logic signed [PRIO_W-1:0] p;
		case (mode)
			0: p = PRIO_W'($urandom_range(0, 255));
			1: p = PRIO_W'(int'($urandom_range(0, 4)) - 2);
			default: begin
				case ($urandom_range(0, 4))
					0: p = -8'sd128;
					1: p = -8'sd127;
					2: p = 8'sd126;
					3: p = 8'sd127;
					default: p = 8'sd0;
				endcase
			end
		endcase
		return p;
	endfunction

	// stimulus
	initial begin
		logic signed [PRIO_W-1:0] fill_prios [16];
		logic [TAG_W-1:0] fill_tags [16];
		int unsigned phase_kind;
		int unsigned phase_len;
		int unsigned prio_mode;
		int unsigned push_pct;
		bit idle_on;
		bit long_hold_done;
		opcode_t op;

		fill_prios = '{8'sd0, 8'sd0, 8'sd127, -8'sd128, 8'sd127, -8'sd1, 8'sd1, 8'sd0,
			-8'sd128, 8'sd127, 8'sd5, 8'sd5, -8'sd1, 8'sd0, 8'sd85, -8'sd86};
		fill_tags = '{8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80, 8'h7f, 8'h02,
			8'hfe, 8'h03, 8'h10, 8'h11, 8'h12, 8'h13, 8'h0f, 8'hf0};

		tracker = new();
		words_sent = 0;
		burst_left = 0;
		long_hold_request = 1'b0;
		long_hold_done = 1'b0;
		req.valid <= 1'b0;
		req.opcode <= OP_PUSH;
		req.task_tag <= '0;
		req.task_priority <= '0;

		// reset
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: pop when empty, fill with extremes and ties, push when full, pop four
		offer_word(OP_POP, 8'hff, -8'sd1, 1'b0);
		for (int i = 0; i < 16; i++)
			offer_word(OP_PUSH, fill_tags[i], fill_prios[i], 1'b0);
		offer_word(OP_PUSH, 8'h5a, 8'sd127, 1'b0);
		for (int i = 0; i < 4; i++)
			offer_word(OP_POP, 8'h00, 8'sd0, 1'b0);
		wait_for_drain();

		// random phases: filling, draining and mixed, with varied priority spread
		while (words_sent < RANDOM_WORDS) begin
			phase_kind = $urandom_range(0, 2);
			phase_len = $urandom_range(8, 40);
			prio_mode = $urandom_range(0, 2);
			idle_on = ($urandom_range(0, 3) != 0);
			// once, hold the receiver off while the sender runs a push-heavy phase
			if (!long_hold_done && words_sent > 300) begin
				phase_kind = 0;
				idle_on = 1'b0;
				long_hold_request = 1'b1;
				long_hold_done = 1'b1;
			end
			push_pct = (phase_kind == 0) ? 85 : (phase_kind == 1) ? 15 : 50;
			for (int unsigned k = 0; k < phase_len; k++) begin
				op = ($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP;
				offer_word(op, TAG_W'($urandom_range(0, 255)), pick_priority(prio_mode),
					idle_on);
			end
			if ($urandom_range(0, 3) == 0)
				wait_for_drain();
		end

		// wrap up
		wait_for_drain();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_results.size() == 0)
			$display("PASS stable_priority_task_queue_core");
		else
			$display("FAIL stable_priority_task_queue_core");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/sptq_pkg.sv
hdl/sptq_if.sv
hdl/sptq_cell.sv
hdl/stable_priority_task_queue_core.sv
tb/stable_priority_task_queue_core_tb.sv
